[rtl/pressure_temp_compensation_defines.svh]
// assertion macros shared by the compensation block
`ifndef PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// same-cycle implication, masked while reset is high
`define PTC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define PTC_ASSERT_NXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ptc_pkg.sv]
// types, register indexes and helpers for the pressure/temperature compensation pipeline
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int IDX_W = 3;
  localparam int CFG_W = 16;

  localparam logic [IDX_W-1:0] REG_MODEL    = 3'd0;
  localparam logic [IDX_W-1:0] REG_SENS     = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFF      = 3'd2;
  localparam logic [IDX_W-1:0] REG_TCS      = 3'd3;
  localparam logic [IDX_W-1:0] REG_TCO      = 3'd4;
  localparam logic [IDX_W-1:0] REG_TREF     = 3'd5;
  localparam logic [IDX_W-1:0] REG_TEMPSENS = 3'd6;

  localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [19:0] VLOW_LIM  = -20'sd1600;
  localparam logic signed [19:0] VLOW_OFS  = 20'sd1500;

  typedef struct packed {
    logic        model;
    logic [15:0] sens;
    logic [15:0] off;
    logic [15:0] tcs;
    logic [15:0] tco;
    logic [15:0] tref;
    logic [15:0] tempsens;
  } cfg_t;

  // first-order terms and squares
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [41:0] sens1;
    logic signed [41:0] off1;
    logic signed [19:0] temp1;
    logic [34:0]        dev2;
    logic [35:0]        e2;
    logic [17:0]        ti_low;
    logic [17:0]        ti_high;
  } front_t;

  // second-order corrected terms
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [41:0] sens2;
    logic signed [41:0] off2;
    logic signed [20:0] temp2;
  } corr_t;

  // signed shift that rounds toward zero like a c division by 2**k
  function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                  input logic [5:0] k);
    logic signed [63:0] bias;
    bias = x[63] ? $signed((64'd1 << k) - 64'd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

[rtl/pressure_temp_compensation.sv]
// top level: calibration registers and the ten-stage compensation pipeline
// done flags the result of each taken start as it leaves the last stage
// throughput: one raw pair per cycle, set by the fully pipelined multipliers
// busy stays low; results cannot be held off and leave one per done pulse
// reset clears the pipeline valids and all calibration registers to zero
`timescale 1ns / 1ps
`include "pressure_temp_compensation_defines.svh"

module pressure_temp_compensation (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [23:0]                d1_raw,
  input  logic [23:0]                d2_raw,
  output logic                       done,
  output logic signed [31:0]         pressure_pa,
  output logic signed [31:0]         temperature_centi,
  input  logic                       wr_en,
  input  logic [ptc_pkg::IDX_W-1:0]  wr_index,
  input  logic [ptc_pkg::CFG_W-1:0]  wr_data
);
  import ptc_pkg::*;

  cfg_t   cfg;
  logic   front_valid, corr_valid;
  front_t front;
  corr_t  corr;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_MODEL:    cfg.model    <= wr_data[0];
        REG_SENS:     cfg.sens     <= wr_data;
        REG_OFF:      cfg.off      <= wr_data;
        REG_TCS:      cfg.tcs      <= wr_data;
        REG_TCO:      cfg.tco      <= wr_data;
        REG_TREF:     cfg.tref     <= wr_data;
        REG_TEMPSENS: cfg.tempsens <= wr_data;
        default: begin
        end
      endcase
    end
  end

  ptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .d1        (d1_raw),
    .d2        (d2_raw),
    .cfg       (cfg),
    .out_valid (front_valid),
    .out       (front)
  );

  ptc_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .model     (cfg.model),
    .in_valid  (front_valid),
    .in        (front),
    .out_valid (corr_valid),
    .out       (corr)
  );

  ptc_press u_press (
    .clk         (clk),
    .rst         (rst),
    .model       (cfg.model),
    .in_valid    (corr_valid),
    .in          (corr),
    .out_valid   (done),
    .pressure    (pressure_pa),
    .temperature (temperature_centi)
  );

  // every transaction comes out of the last stage with done, and nothing else does
  `PTC_ASSERT_IMP(a_latency, clk, rst, start && !busy, ##10 done, "result missing after start")
  `PTC_ASSERT_IMP(a_no_orphan, clk, rst, done, $past(start && !busy, 10), "result without start")
  `PTC_ASSERT_NXT(a_reset_flush, clk, rst, !done, "pipeline not flushed by reset")

endmodule

[rtl/ptc_front.sv]
// stages 1-4: dT, first-order products, SENS/OFF/TEMP and the squared terms
`timescale 1ns / 1ps

module ptc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [23:0]     d1,
  input  logic [23:0]     d2,
  input  ptc_pkg::cfg_t   cfg,
  output logic            out_valid,
  output ptc_pkg::front_t out
);
  import ptc_pkg::*;

  // stage 1
  logic               v1;
  logic [23:0]        d1_s1;
  logic signed [24:0] dt;
  logic signed [24:0] dt_next;

  // stage 2
  logic               v2;
  logic [23:0]        d1_s2;
  logic signed [41:0] tcs_dt, tco_dt, ts_dt;
  logic signed [41:0] tcs_dt_next, tco_dt_next, ts_dt_next;
  logic [47:0]        dt2;
  logic signed [49:0] dt2_next;

  // stage 3
  logic               v3;
  logic [23:0]        d1_s3;
  logic signed [41:0] sens1, off1;
  logic signed [41:0] sens1_next, off1_next;
  logic signed [17:0] dev;
  logic signed [19:0] temp1;
  logic [17:0]        ti_low, ti_high;
  logic signed [63:0] tcs_q, tco_q, dev_q;
  logic signed [41:0] sens_base, off_base;
  logic [51:0]        dt2_x11;
  logic [49:0]        dt2_x3;
  logic [17:0]        ti_low_next;

  // stage 4
  logic signed [35:0] dev2_next;
  logic signed [19:0] e;
  logic signed [39:0] e2_next;

  assign dt_next = $signed({1'b0, d2}) - $signed({1'b0, cfg.tref, 8'h00});

  assign tcs_dt_next = $signed({26'd0, cfg.tcs}) * 42'(dt);
  assign tco_dt_next = $signed({26'd0, cfg.tco}) * 42'(dt);
  assign ts_dt_next  = $signed({26'd0, cfg.tempsens}) * 42'(dt);
  assign dt2_next    = 50'(dt) * 50'(dt);

  assign sens_base = cfg.model ? $signed({11'd0, cfg.sens, 15'd0})
                               : $signed({10'd0, cfg.sens, 16'd0});
  assign off_base  = cfg.model ? $signed({10'd0, cfg.off, 16'd0})
                               : $signed({9'd0, cfg.off, 17'd0});
  assign tcs_q = sdiv_pow2(64'(tcs_dt), cfg.model ? 6'd8 : 6'd7);
  assign tco_q = sdiv_pow2(64'(tco_dt), cfg.model ? 6'd7 : 6'd6);
  assign dev_q = sdiv_pow2(64'(ts_dt), 6'd23);
  assign sens1_next = sens_base + $signed(tcs_q[41:0]);
  assign off1_next  = off_base + $signed(tco_q[41:0]);

  // dT squared is never negative, so these divisions are plain shifts
  assign dt2_x11 = 52'(dt2) * 52'd11;
  assign dt2_x3  = 50'(dt2) * 50'd3;
  assign ti_low_next = cfg.model ? 18'(dt2_x3[49:33]) : 18'(dt2_x11[51:35]);

  assign dev2_next = 36'(dev) * 36'(dev);
  assign e         = temp1 + VLOW_OFS;
  assign e2_next   = 40'(e) * 40'(e);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
    d1_s1   <= d1;
    dt      <= dt_next;
    d1_s2   <= d1_s1;
    tcs_dt  <= tcs_dt_next;
    tco_dt  <= tco_dt_next;
    ts_dt   <= ts_dt_next;
    dt2     <= dt2_next[47:0];
    d1_s3   <= d1_s2;
    sens1   <= sens1_next;
    off1    <= off1_next;
    dev     <= dev_q[17:0];
    temp1   <= 20'(dev_q) + TEMP_REF;
    ti_low  <= ti_low_next;
    ti_high <= 18'(dt2[47:36]);
    out.d1      <= d1_s3;
    out.sens1   <= sens1;
    out.off1    <= off1;
    out.temp1   <= temp1;
    out.dev2    <= dev2_next[34:0];
    out.e2      <= e2_next[35:0];
    out.ti_low  <= ti_low;
    out.ti_high <= ti_high;
  end

endmodule

[rtl/ptc_corr.sv]
// stages 5-6: second-order low, very-low and high temperature corrections
`timescale 1ns / 1ps

module ptc_corr (
  input  logic            clk,
  input  logic            rst,
  input  logic            model,
  input  logic            in_valid,
  input  ptc_pkg::front_t in,
  output logic            out_valid,
  output ptc_pkg::corr_t  out
);
  import ptc_pkg::*;

  logic        low, vlow;
  logic [39:0] dev2_x31, dev2_x63, dev2_x3, dev2_x5, e2_x7, e2_x4;
  logic [39:0] offi_next, sensi_next;
  logic [17:0] ti_next;

  logic               v5;
  front_t             s5;
  logic [39:0]        offi, sensi;
  logic [17:0]        ti;

  assign low  = in.temp1 < TEMP_REF;
  assign vlow = in.temp1 <= VLOW_LIM;

  assign dev2_x31 = 40'(in.dev2) * 40'd31;
  assign dev2_x63 = 40'(in.dev2) * 40'd63;
  assign dev2_x3  = 40'(in.dev2) * 40'd3;
  assign dev2_x5  = 40'(in.dev2) * 40'd5;
  assign e2_x7    = 40'(in.e2) * 40'd7;
  assign e2_x4    = 40'(in.e2) * 40'd4;

  always_comb begin
    ti_next    = '0;
    offi_next  = '0;
    sensi_next = '0;
    if (!model) begin
      if (low) begin
        ti_next    = in.ti_low;
        offi_next  = 40'(dev2_x31[39:3]);
        sensi_next = 40'(dev2_x63[39:5]);
      end
    end else if (low) begin
      ti_next    = in.ti_low;
      offi_next  = 40'(dev2_x3[39:1]) + (vlow ? e2_x7 : 40'd0);
      sensi_next = 40'(dev2_x5[39:3]) + (vlow ? e2_x4 : 40'd0);
    end else begin
      ti_next   = in.ti_high;
      offi_next = 40'(in.dev2[34:4]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v5        <= in_valid;
      out_valid <= v5;
    end
    s5    <= in;
    offi  <= offi_next;
    sensi <= sensi_next;
    ti    <= ti_next;
    out.d1    <= s5.d1;
    out.sens2 <= s5.sens1 - $signed({2'b00, sensi});
    out.off2  <= s5.off1 - $signed({2'b00, offi});
    out.temp2 <= 21'(s5.temp1) - $signed({3'b000, ti});
  end

endmodule

[rtl/ptc_press.sv]
// stages 7-10: split d1*SENS product, scaling, offset and final pressure
`timescale 1ns / 1ps

module ptc_press (
  input  logic                clk,
  input  logic                rst,
  input  logic                model,
  input  logic                in_valid,
  input  ptc_pkg::corr_t      in,
  output logic                out_valid,
  output logic signed [31:0]  pressure,
  output logic signed [31:0]  temperature
);
  import ptc_pkg::*;

  // stage 7: two partial products of d1 against the low and high halves of SENS
  logic               v7;
  logic [44:0]        pp_lo;
  logic signed [45:0] pp_hi;
  logic signed [41:0] off_s7;
  logic signed [20:0] temp_s7;

  // stage 8
  logic               v8;
  logic signed [63:0] prod;
  logic signed [41:0] off_s8;
  logic signed [20:0] temp_s8;

  // stage 9
  logic               v9;
  logic signed [43:0] p1;
  logic signed [20:0] temp_s9;
  logic signed [63:0] prod_q, p1_next;

  // stage 10
  logic signed [63:0] p_q;
  logic [31:0]        p_next;

  assign prod_q  = sdiv_pow2(prod, 6'd21);
  assign p1_next = prod_q - 64'(off_s8);
  assign p_q     = sdiv_pow2(64'(p1), model ? 6'd13 : 6'd15);
  assign p_next  = model ? p_q[31:0] * 32'd10 : p_q[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7        <= 1'b0;
      v8        <= 1'b0;
      v9        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v7        <= in_valid;
      v8        <= v7;
      v9        <= v8;
      out_valid <= v9;
    end
    pp_lo   <= 45'(in.d1) * 45'(in.sens2[20:0]);
    pp_hi   <= $signed({22'd0, in.d1}) * 46'($signed(in.sens2[41:21]));
    off_s7  <= in.off2;
    temp_s7 <= in.temp2;
    // true product stays well inside 64 bits, so wrapping here is exact
    prod    <= $signed((64'(pp_hi) <<< 21) + {19'd0, pp_lo});
    off_s8  <= off_s7;
    temp_s8 <= temp_s7;
    p1      <= p1_next[43:0];
    temp_s9 <= temp_s8;
    pressure    <= $signed(p_next);
    temperature <= 32'(temp_s9);
  end

endmodule

[sim/tb.sv]
// testbench for the pressure/temperature compensation pipeline
`timescale 1ns / 1ps

module tb;
  import ptc_pkg::*;

  localparam int LATENCY = 10;
  localparam int RANDOM_PAIRS = 1800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_DIRECTED = 23;
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic [23:0]        d1;
    logic [23:0]        d2;
    logic signed [31:0] pres;
    logic signed [31:0] temp;
  } reading_t;

  typedef struct packed {
    logic [2:0]         preset;
    logic [23:0]        d1;
    logic [23:0]        d2;
    logic               known;
    logic signed [31:0] pres;
    logic signed [31:0] temp;
  } dir_row_t;

  // model, sens, off, tcs, tco, tref, tempsens
  localparam cfg_t PRESETS [6] = '{
    '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{1'b0, 16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165},
    '{1'b1, 16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165},
    '{1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff},
    '{1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff},
    '{1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
  };

  // with zero calibration pressure is zero, and dT changes temperature only through the high-temperature correction
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{3'd0, 24'h000000, 24'h000000, 1'b1, 32'sd0, 32'sd2000},
    '{3'd0, 24'hffffff, 24'hffffff, 1'b1, 32'sd0, 32'sd2000},
    '{3'd0, 24'haaaaaa, 24'h555555, 1'b1, 32'sd0, 32'sd2000},
    '{3'd5, 24'h000000, 24'h000000, 1'b1, 32'sd0, 32'sd2000},
    '{3'd5, 24'hffffff, 24'h000000, 1'b1, 32'sd0, 32'sd2000},
    '{3'd5, 24'h000000, 24'hffffff, 1'b0, 32'sd0, 32'sd0},
    // reference temperature, low side, both raw extremes
    '{3'd1, 24'd6465100, 24'd8077568, 1'b0, 32'sd0, 32'sd0},
    '{3'd1, 24'd6465100, 24'd4000000, 1'b0, 32'sd0, 32'sd0},
    '{3'd1, 24'h000000, 24'h000000, 1'b0, 32'sd0, 32'sd0},
    '{3'd1, 24'hffffff, 24'hffffff, 1'b0, 32'sd0, 32'sd0},
    '{3'd1, 24'hffffff, 24'h000000, 1'b0, 32'sd0, 32'sd0},
    '{3'd1, 24'd6465100, 24'd8077270, 1'b0, 32'sd0, 32'sd0},
    // 30-bar set: 2000 exactly, 1999, high, low, very-low edge -1600 and -1598
    '{3'd2, 24'd6465100, 24'd8077568, 1'b0, 32'sd0, 32'sd0},
    '{3'd2, 24'd6465100, 24'd8077270, 1'b0, 32'sd0, 32'sd0},
    '{3'd2, 24'hffffff, 24'hffffff, 1'b0, 32'sd0, 32'sd0},
    '{3'd2, 24'd6465100, 24'd7277568, 1'b0, 32'sd0, 32'sd0},
    '{3'd2, 24'd6465100, 24'd7005268, 1'b0, 32'sd0, 32'sd0},
    '{3'd2, 24'd6465100, 24'd7005668, 1'b0, 32'sd0, 32'sd0},
    '{3'd2, 24'd6465100, 24'd6000000, 1'b0, 32'sd0, 32'sd0},
    '{3'd3, 24'hffffff, 24'h000000, 1'b0, 32'sd0, 32'sd0},
    '{3'd3, 24'h000000, 24'hffffff, 1'b0, 32'sd0, 32'sd0},
    '{3'd4, 24'hffffff, 24'h000000, 1'b0, 32'sd0, 32'sd0},
    '{3'd4, 24'hffffff, 24'hffffff, 1'b0, 32'sd0, 32'sd0}
  };

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [23:0]              d1_raw;
  logic [23:0]              d2_raw;
  logic                     done;
  logic signed [31:0]       pressure_pa;
  logic signed [31:0]       temperature_centi;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_index;
  logic [CFG_W-1:0]         wr_data;

  cfg_t     shadow_cfg;
  reading_t pending_readings [$];
  int       mismatch_count;
  int       cycle_count;

  pressure_temp_compensation uut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .d1_raw            (d1_raw),
    .d2_raw            (d2_raw),
    .done              (done),
    .pressure_pa       (pressure_pa),
    .temperature_centi (temperature_centi),
    .wr_en             (wr_en),
    .wr_index          (wr_index),
    .wr_data           (wr_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // exact 64-bit second-order compensation, divisions truncate toward zero
  function automatic void compensate(input cfg_t c, input logic [23:0] d1, input logic [23:0] d2,
                                     output logic signed [31:0] pres,
                                     output logic signed [31:0] temp_res);
    longint d1v, d2v, k1, k2, k3, k4, k5, k6;
    longint dt, sens, off, temp, dev, ti, offi, sensi, e, p, scaled;
    d1v = d1;
    d2v = d2;
    k1 = c.sens;
    k2 = c.off;
    k3 = c.tcs;
    k4 = c.tco;
    k5 = c.tref;
    k6 = c.tempsens;
    dt = d2v - k5 * 256;
    if (!c.model) begin
      sens = k1 * 65536 + (k3 * dt) / 128;
      off = k2 * 131072 + (k4 * dt) / 64;
    end else begin
      sens = k1 * 32768 + (k3 * dt) / 256;
      off = k2 * 65536 + (k4 * dt) / 128;
    end
    temp = 2000 + (dt * k6) / 64'sd8388608;
    dev = temp - 2000;
    ti = 0;
    offi = 0;
    sensi = 0;
    if (!c.model) begin
      if (temp < 2000) begin
        ti = (11 * dt * dt) / 64'sd34359738368;
        offi = (31 * dev * dev) / 8;
        sensi = (63 * dev * dev) / 32;
      end
    end else if (temp < 2000) begin
      ti = (3 * dt * dt) / 64'sd8589934592;
      offi = (3 * dev * dev) / 2;
      sensi = (5 * dev * dev) / 8;
      if (temp <= -1600) begin
        e = temp + 1500;
        offi = offi + 7 * e * e;
        sensi = sensi + 4 * e * e;
      end
    end else begin
      ti = (2 * dt * dt) / 64'sd137438953472;
      offi = (dev * dev) / 16;
    end
    sens = sens - sensi;
    off = off - offi;
    temp = temp - ti;
    p = (d1v * sens) / 2097152 - off;
    // 30-bar result is in 0.1 mbar, scaled to Pa with 32-bit wrap
    if (c.model) begin
      p = p / 8192;
      scaled = p * 10;
    end else begin
      scaled = p / 32768;
    end
    pres = scaled[31:0];
    temp_res = temp[31:0];
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_pair(input logic [23:0] d1, input logic [23:0] d2, input int gap,
                           input logic known, input logic signed [31:0] pres,
                           input logic signed [31:0] temp);
    reading_t r;
    r.d1 = d1;
    r.d2 = d2;
    if (known) begin
      r.pres = pres;
      r.temp = temp;
    end else begin
      compensate(shadow_cfg, d1, d2, r.pres, r.temp);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    d1_raw <= d1;
    d2_raw <= d2;
    do @(posedge clk); while (busy);
    pending_readings.push_back(r);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // writes every register plus the unused index, which must be ignored
  task automatic program_calibration(input cfg_t c);
    logic [CFG_W-1:0] value;
    for (int i = 0; i <= 7; i++) begin
      case (IDX_W'(i))
        REG_MODEL:    value = {15'($urandom_range(0, 32767)), c.model};
        REG_SENS:     value = c.sens;
        REG_OFF:      value = c.off;
        REG_TCS:      value = c.tcs;
        REG_TCO:      value = c.tco;
        REG_TREF:     value = c.tref;
        REG_TEMPSENS: value = c.tempsens;
        default:      value = 16'($urandom_range(0, 65535));
      endcase
      wr_en <= 1'b1;
      wr_index <= IDX_W'(i);
      wr_data <= value;
      @(posedge clk);
      case (IDX_W'(i))
        REG_MODEL:    shadow_cfg.model = value[0];
        REG_SENS:     shadow_cfg.sens = value;
        REG_OFF:      shadow_cfg.off = value;
        REG_TCS:      shadow_cfg.tcs = value;
        REG_TCO:      shadow_cfg.tco = value;
        REG_TREF:     shadow_cfg.tref = value;
        REG_TEMPSENS: shadow_cfg.tempsens = value;
        REG_SPARE:    ;
        default:      ;
      endcase
    end
    wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    reading_t want;
    if (!rst && done) begin
      if (pending_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: pressure %0d temperature %0d",
                   pressure_pa, temperature_centi);
      end else begin
        want = pending_readings.pop_front();
        if (pressure_pa !== want.pres || temperature_centi !== want.temp) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch d1=%h d2=%h: pressure exp %0d got %0d, temperature exp %0d got %0d",
                     want.d1, want.d2, want.pres, pressure_pa, want.temp, temperature_centi);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    cfg_t         c;
    int           cur_preset;
    int           sent;
    int           phase_len;
    int           max_gap;
    int           offset;
    longint       aim;
    logic [23:0]  d1;
    logic [23:0]  d2;
    rst = 1'b1;
    start = 1'b0;
    d1_raw = '0;
    d2_raw = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    shadow_cfg = '0;
    mismatch_count = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed rows; the first ones run on the reset calibration
    cur_preset = 0;
    for (int n = 0; n < NUM_DIRECTED; n++) begin
      if (int'(DIRECTED[n].preset) != cur_preset) begin
        wait_drained();
        cur_preset = DIRECTED[n].preset;
        program_calibration(PRESETS[cur_preset]);
      end
      send_pair(DIRECTED[n].d1, DIRECTED[n].d2, $urandom_range(0, 19), DIRECTED[n].known,
                DIRECTED[n].pres, DIRECTED[n].temp);
    end

    // random phases, each with its own calibration and idling pattern
    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      c.model = 1'($urandom_range(0, 1));
      c.sens = pick_word();
      c.off = pick_word();
      c.tcs = pick_word();
      c.tco = pick_word();
      c.tref = pick_word();
      c.tempsens = pick_word();
      wait_drained();
      program_calibration(c);
      phase_len = $urandom_range(60, 200);
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 19;
      for (int k = 0; k < phase_len && sent < RANDOM_PAIRS; k++) begin
        case ($urandom_range(0, 9))
          0: d1 = 24'h000000;
          1: d1 = 24'hffffff;
          default: d1 = 24'($urandom_range(0, 24'hffffff));
        endcase
        case ($urandom_range(0, 9))
          0: d2 = 24'h000000;
          1: d2 = 24'hffffff;
          2, 3: d2 = 24'($urandom_range(0, 24'hffffff));
          default: begin
            // near the reference temperature so all branches get hit
            offset = int'($urandom_range(0, 4194304)) - 2097152;
            aim = shadow_cfg.tref;
            aim = aim * 256 + offset;
            if (aim < 0) aim = 0;
            if (aim > 64'sd16777215) aim = 64'sd16777215;
            d2 = aim[23:0];
          end
        endcase
        send_pair(d1, d2, $urandom_range(0, max_gap), 1'b0, 32'sd0, 32'sd0);
        sent++;
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[pressure_temp_compensation.f]
+incdir+rtl
rtl/ptc_pkg.sv
rtl/ptc_front.sv
rtl/ptc_corr.sv
rtl/ptc_press.sv
rtl/pressure_temp_compensation.sv
sim/tb.sv
